[rtl/bhp_pkg.sv]
package bhp_pkg;

  // parser phases, one-hot
  typedef enum logic [9:0] {
    PH_MAGIC     = 10'b00_0000_0001,
    PH_SECTION   = 10'b00_0000_0010,
    PH_VERSION   = 10'b00_0000_0100,
    PH_POOLKIND  = 10'b00_0000_1000,
    PH_POOLCOUNT = 10'b00_0001_0000,
    PH_PREFIX    = 10'b00_0010_0000,
    PH_TEXTLEN   = 10'b00_0100_0000,
    PH_SKIP      = 10'b00_1000_0000,
    PH_SELECTOR  = 10'b01_0000_0000,
    PH_DONE      = 10'b10_0000_0000
  } phase_t;

  localparam int unsigned VARINT_W  = 28;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned DIGIT_W   = 7;

  localparam logic [7:0] MAGIC_0 = 8'h4D;  // 'M'
  localparam logic [7:0] MAGIC_1 = 8'h44;  // 'D'
  localparam logic [7:0] MAGIC_2 = 8'h32;  // '2'
  localparam logic [7:0] MAGIC_3 = 8'h00;

  localparam logic [7:0] SECTION_POOL     = 8'd3;
  localparam logic [7:0] VERSION_POOLKIND = 8'd4;
  localparam logic [7:0] POOL_KIND_PREFIX = 8'd1;
  localparam logic [1:0] VARINT_LAST_IDX  = 2'd3;
  localparam logic [1:0] MAGIC_LAST_IDX   = 2'd3;
  localparam logic [POS_W-1:0] MIN_FILE_LEN    = 32'd5;
  localparam logic [POS_W-1:0] DEFAULT_PROG_ST = 32'd5;
  localparam logic [POS_W-1:0] POS_MAX         = 32'hFFFF_FFFF;

  typedef struct packed {
    logic                accepted;
    logic                magic_ok;
    logic [7:0]          section_code;
    logic [7:0]          format_version;
    logic [VARINT_W-1:0] pool_entries;
    logic [VARINT_W-1:0] selector_entries;
    logic [POS_W-1:0]    program_start;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = MAGIC_0;
      2'd1:    m = MAGIC_1;
      2'd2:    m = MAGIC_2;
      default: m = MAGIC_3;
    endcase
    return m;
  endfunction

endpackage

[rtl/bhp_if.sv]
interface bhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bhp_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        magic_ok;
  logic [7:0]  section_code;
  logic [7:0]  format_version;
  logic [27:0] pool_entries;
  logic [27:0] selector_entries;
  logic [31:0] program_start;

  modport source (output valid, output accepted, output magic_ok, output section_code,
                  output format_version, output pool_entries, output selector_entries,
                  output program_start, input ready);
  modport sink   (input valid, input accepted, input magic_ok, input section_code,
                  input format_version, input pool_entries, input selector_entries,
                  input program_start, output ready);
endinterface

[rtl/bhp_core.sv]
module bhp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              res_push,
  output bhp_pkg::result_t  res
);

  localparam int unsigned VW = bhp_pkg::VARINT_W;
  localparam int unsigned PW = bhp_pkg::POS_W;

  bhp_pkg::phase_t phase_r, phase_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [VW-1:0] accum_r, accum_nxt;
  logic [1:0]    taken_r, taken_nxt;
  logic          magic_r, magic_nxt;
  logic [7:0]    section_r, section_nxt;
  logic [7:0]    version_r, version_nxt;
  logic [7:0]    pkind_r, pkind_nxt;
  logic [VW-1:0] pcount_r, pcount_nxt;
  logic [VW-1:0] pidx_r, pidx_nxt;
  logic [VW-1:0] skip_r, skip_nxt;
  logic [VW-1:0] scount_r, scount_nxt;
  logic [PW-1:0] pstart_r, pstart_nxt;

  logic [PW-1:0] pos_inc;
  logic [VW-1:0] digit;
  logic [VW-1:0] vint_val;
  logic          vint_done;
  logic [1:0]    vint_taken;
  logic [VW-1:0] skip_dec;
  logic          entry_first;
  logic [VW-1:0] entry_idx;
  logic [VW-1:0] entry_cnt;
  logic          entry_more;
  bhp_pkg::phase_t entry_phase;

  // saturating byte counter
  assign pos_inc = (pos_r == bhp_pkg::POS_MAX) ? pos_r : pos_r + 1'b1;

  // one LEB128 digit placed by the count of digits already taken
  always_comb begin
    case (taken_r)
      2'd0:    digit = {21'b0, data_byte[6:0]};
      2'd1:    digit = {14'b0, data_byte[6:0], 7'b0};
      2'd2:    digit = {7'b0, data_byte[6:0], 14'b0};
      default: digit = {data_byte[6:0], 21'b0};
    endcase
  end

  assign vint_val   = accum_r | digit;
  assign vint_done  = !data_byte[7] || (taken_r == bhp_pkg::VARINT_LAST_IDX);
  assign vint_taken = vint_done ? 2'd0 : taken_r + 2'd1;
  assign skip_dec   = skip_r - 1'b1;

  // next pool entry or the selector count
  assign entry_first = (phase_r == bhp_pkg::PH_POOLCOUNT);
  assign entry_idx   = entry_first ? '0 : pidx_r + 1'b1;
  assign entry_cnt   = entry_first ? vint_val : pcount_r;
  assign entry_more  = entry_idx < entry_cnt;
  assign entry_phase = !entry_more ? bhp_pkg::PH_SELECTOR :
                       (pkind_r == bhp_pkg::POOL_KIND_PREFIX) ? bhp_pkg::PH_PREFIX :
                       bhp_pkg::PH_TEXTLEN;

  // per-beat state update
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_inc;
    accum_nxt   = accum_r;
    taken_nxt   = taken_r;
    magic_nxt   = magic_r;
    section_nxt = section_r;
    version_nxt = version_r;
    pkind_nxt   = pkind_r;
    pcount_nxt  = pcount_r;
    pidx_nxt    = pidx_r;
    skip_nxt    = skip_r;
    scount_nxt  = scount_r;
    pstart_nxt  = pstart_r;

    unique case (phase_r)
      bhp_pkg::PH_MAGIC: begin
        if (data_byte != bhp_pkg::magic_byte(pos_r[1:0])) magic_nxt = 1'b0;
        if (pos_r[1:0] == bhp_pkg::MAGIC_LAST_IDX) phase_nxt = bhp_pkg::PH_SECTION;
      end
      bhp_pkg::PH_SECTION: begin
        section_nxt = data_byte;
        phase_nxt   = bhp_pkg::PH_VERSION;
      end
      bhp_pkg::PH_VERSION: begin
        version_nxt = data_byte;
        if (!magic_r || section_r != bhp_pkg::SECTION_POOL) begin
          phase_nxt = bhp_pkg::PH_DONE;
        end else begin
          pstart_nxt = pos_inc;
          accum_nxt  = '0;
          taken_nxt  = '0;
          phase_nxt  = (data_byte >= bhp_pkg::VERSION_POOLKIND) ?
                       bhp_pkg::PH_POOLKIND : bhp_pkg::PH_POOLCOUNT;
        end
      end
      bhp_pkg::PH_POOLKIND: begin
        pstart_nxt = pos_inc;
        pkind_nxt  = data_byte;
        accum_nxt  = '0;
        taken_nxt  = '0;
        phase_nxt  = bhp_pkg::PH_POOLCOUNT;
      end
      bhp_pkg::PH_POOLCOUNT: begin
        pstart_nxt = pos_inc;
        pcount_nxt = vint_val;
        accum_nxt  = vint_val;
        taken_nxt  = vint_taken;
        if (vint_done) begin
          pidx_nxt  = '0;
          accum_nxt = '0;
          phase_nxt = entry_phase;
        end
      end
      bhp_pkg::PH_PREFIX: begin
        pstart_nxt = pos_inc;
        accum_nxt  = vint_val;
        taken_nxt  = vint_taken;
        if (vint_done) begin
          accum_nxt = '0;
          phase_nxt = bhp_pkg::PH_TEXTLEN;
        end
      end
      bhp_pkg::PH_TEXTLEN: begin
        pstart_nxt = pos_inc;
        accum_nxt  = vint_val;
        taken_nxt  = vint_taken;
        if (vint_done) begin
          if (vint_val != '0) begin
            skip_nxt  = vint_val;
            phase_nxt = bhp_pkg::PH_SKIP;
          end else begin
            pidx_nxt  = entry_idx;
            accum_nxt = '0;
            phase_nxt = entry_phase;
          end
        end
      end
      bhp_pkg::PH_SKIP: begin
        pstart_nxt = pos_inc;
        skip_nxt   = skip_dec;
        if (skip_dec == '0) begin
          pidx_nxt  = entry_idx;
          accum_nxt = '0;
          taken_nxt = '0;
          phase_nxt = entry_phase;
        end
      end
      bhp_pkg::PH_SELECTOR: begin
        pstart_nxt = pos_inc;
        accum_nxt  = vint_val;
        taken_nxt  = vint_taken;
        scount_nxt = vint_val;
        if (vint_done) phase_nxt = bhp_pkg::PH_DONE;
      end
      bhp_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // result on the last beat of a file
  always_comb begin
    res_push = fire && last_byte;
    if (pos_inc < bhp_pkg::MIN_FILE_LEN) begin
      res.accepted         = 1'b0;
      res.magic_ok         = 1'b0;
      res.section_code     = '0;
      res.format_version   = '0;
      res.pool_entries     = '0;
      res.selector_entries = '0;
      res.program_start    = bhp_pkg::DEFAULT_PROG_ST;
    end else begin
      res.accepted         = magic_nxt;
      res.magic_ok         = magic_nxt;
      res.section_code     = section_nxt;
      res.format_version   = version_nxt;
      res.pool_entries     = pcount_nxt;
      res.selector_entries = scount_nxt;
      res.program_start    = pstart_nxt;
    end
  end

  // state registers, back to the start after each file
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last_byte)) begin
      phase_r   <= bhp_pkg::PH_MAGIC;
      pos_r     <= '0;
      accum_r   <= '0;
      taken_r   <= '0;
      magic_r   <= 1'b1;
      section_r <= '0;
      version_r <= '0;
      pkind_r   <= '0;
      pcount_r  <= '0;
      pidx_r    <= '0;
      skip_r    <= '0;
      scount_r  <= '0;
      pstart_r  <= bhp_pkg::DEFAULT_PROG_ST;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      accum_r   <= accum_nxt;
      taken_r   <= taken_nxt;
      magic_r   <= magic_nxt;
      section_r <= section_nxt;
      version_r <= version_nxt;
      pkind_r   <= pkind_nxt;
      pcount_r  <= pcount_nxt;
      pidx_r    <= pidx_nxt;
      skip_r    <= skip_nxt;
      scount_r  <= scount_nxt;
      pstart_r  <= pstart_nxt;
    end
  end

endmodule

[rtl/bytecode_header_parser_unit.sv]
// Streaming header parser for MD2 bytecode files. Bytes enter one per beat on
// in_ch, with last_byte set on the final byte of a file; one summary beat
// leaves on out_ch per file (accept flag, magic check, section, version, pool
// and selector counts, program start offset), and the parser then starts
// afresh on the next byte. A byte is taken every clock while in_ch.ready is
// high: each beat updates the parser state in combinational logic, and the
// summary is registered into the output register, or into the skid entry if
// that is still held. A two-entry result buffer lets input keep flowing while
// a summary waits; in_ch.ready drops only when both entries are held.
module bytecode_header_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  bhp_in_if.sink      in_ch,
  bhp_out_if.source   out_ch
);

  logic             fire;
  logic             res_push;
  bhp_pkg::result_t res;
  logic             pop;

  logic             out_valid_r;
  bhp_pkg::result_t out_data_r;
  logic             skid_valid_r;
  bhp_pkg::result_t skid_data_r;

  assign in_ch.ready = !skid_valid_r;
  assign fire        = in_ch.valid && in_ch.ready;
  assign pop         = out_valid_r && out_ch.ready;

  bhp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .res_push  (res_push),
    .res       (res)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (res_push) begin
      if (!out_valid_r || pop) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.accepted         = out_data_r.accepted;
  assign out_ch.magic_ok         = out_data_r.magic_ok;
  assign out_ch.section_code     = out_data_r.section_code;
  assign out_ch.format_version   = out_data_r.format_version;
  assign out_ch.pool_entries     = out_data_r.pool_entries;
  assign out_ch.selector_entries = out_data_r.selector_entries;
  assign out_ch.program_start    = out_data_r.program_start;

endmodule
